### rtl/vector2d_cordic_unit_macros.svh
// assertion macros used by the checker
`ifndef VECTOR2D_CORDIC_UNIT_MACROS_SVH
`define VECTOR2D_CORDIC_UNIT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define VC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vector unit check failed");

// next-cycle implication, ignored while in reset
`define VC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vector unit check failed");

`endif

### rtl/vc_pkg.sv
`default_nettype none
package vc_pkg;

  localparam int XW    = 44;
  localparam int ZW    = 34;
  localparam int GUARD = 8;

  localparam logic [29:0] INVK_Q30 = 30'd652032874;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_NEG       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DOT       = 4'd4,
    OP_CROSS     = 4'd5,
    OP_ROT       = 4'd6,
    OP_ROT_ABOUT = 4'd7,
    OP_MAG       = 4'd8,
    OP_UNIT      = 4'd9,
    OP_ANGLE     = 4'd10,
    OP_EQ        = 4'd11,
    OP_WITHIN    = 4'd12
  } op_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 vec;
  } lane_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] sc;
    logic [15:0]        ang;
    logic               flag;
    logic [1:0]         st;
  } side_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    r.ovf = 1'b1;
    if (v > 66'sd2147483647) begin
      r.val = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r.val = 32'sh80000000;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // fold the angle into the right half plane before rotating
  function automatic lane_t rot_prep(input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y,
                                     input logic [31:0] ang);
    lane_t       r;
    logic [31:0] q;
    logic [31:0] a;
    q = ang + 32'h40000000;
    a = ang;
    r.x = x;
    r.y = y;
    r.vec = 1'b0;
    if (q[31]) begin
      r.x = -x;
      r.y = -y;
      a = ang + 32'h80000000;
    end
    r.z = ZW'($signed(a));
    return r;
  endfunction

  function automatic lane_t vec_prep(input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y);
    lane_t r;
    r.vec = 1'b1;
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x[XW-1]) begin
      r.x = -x;
      r.y = -y;
      r.z = ZW'(64'h80000000);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/vc_cell.sv
`default_nettype none
module vc_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  vc_pkg::lane_t in_a,
  input  vc_pkg::lane_t in_b,
  input  vc_pkg::side_t in_side,
  output logic          out_valid,
  output vc_pkg::lane_t out_a,
  output vc_pkg::lane_t out_b,
  output vc_pkg::side_t out_side
);
  import vc_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[STAGE]);

  logic  valid_r;
  lane_t a_r, b_r, a_nxt, b_nxt;
  side_t side_r;

  // one micro-rotation; vectoring drives y to zero, rotation drives z to zero
  function automatic lane_t step(input lane_t l);
    lane_t                r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 dn;
    xs = l.x >>> STAGE;
    ys = l.y >>> STAGE;
    dn = l.vec ? l.y[XW-1] : !l.z[ZW-1];
    r.vec = l.vec;
    if (dn) begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.z = l.z - ANG;
    end else begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.z = l.z + ANG;
    end
    return r;
  endfunction

  always_comb begin
    a_nxt = step(in_a);
    b_nxt = step(in_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

### rtl/vc_chain.sv
`default_nettype none
module vc_chain #(
  parameter int unsigned LEN = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  vc_pkg::lane_t in_a,
  input  vc_pkg::lane_t in_b,
  input  vc_pkg::side_t in_side,
  output logic          out_valid,
  output vc_pkg::lane_t out_a,
  output vc_pkg::lane_t out_b,
  output vc_pkg::side_t out_side
);
  import vc_pkg::*;

  logic  v_w    [LEN+1];
  lane_t a_w    [LEN+1];
  lane_t b_w    [LEN+1];
  side_t side_w [LEN+1];

  assign v_w[0]    = in_valid;
  assign a_w[0]    = in_a;
  assign b_w[0]    = in_b;
  assign side_w[0] = in_side;

  for (genvar g = 0; g < LEN; g++) begin : g_cell
    vc_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (v_w[g]),
      .in_a     (a_w[g]),
      .in_b     (b_w[g]),
      .in_side  (side_w[g]),
      .out_valid(v_w[g+1]),
      .out_a    (a_w[g+1]),
      .out_b    (b_w[g+1]),
      .out_side (side_w[g+1])
    );
  end

  assign out_valid = v_w[LEN];
  assign out_a     = a_w[LEN];
  assign out_b     = b_w[LEN];
  assign out_side  = side_w[LEN];
endmodule
`default_nettype wire

### rtl/vector2d_cordic_unit.sv
// channel   | handshake             | payload
// in        | in_valid / in_ready   | opcode, ax, ay, bx, by, factor, turn
// out       | out_valid / out_ready | rx, ry, scalar_out, angle_out, flag, status
// cfg       | cfg_valid / cfg_ready | data (epsilon)
//
// one transaction per cycle sustained while out_ready stays high
// two front stages (input, multipliers), a vectoring/rotation cell row, one mid stage,
// a second rotation cell row for the unit vector, then the output register
// the whole pipeline advances when the output register is empty or taken
// reset clears the valid bits and epsilon; cfg_ready is always high
`default_nettype none
module vector2d_cordic_unit #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by,
  input  logic signed [31:0] in_factor,
  input  logic [15:0]        in_turn,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic signed [31:0] out_scalar_out,
  output logic [15:0]        out_angle_out,
  output logic               out_flag,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data
);
  import vc_pkg::*;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [XW-1:0] UNIT_K =
    XW'(((64'd1 << FRAC_BITS) * 64'd652032874 + 64'd2097152) >> 22);

  function automatic logic signed [XW-1:0] prescale(input logic signed [32:0] v);
    logic signed [63:0] p;
    p = 64'(v) * $signed({34'd0, INVK_Q30});
    p = p + 64'sd2097152;
    return XW'(p >>> 22);
  endfunction

  function automatic logic signed [65:0] rnd_g(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = (XW+1)'(v) + (XW+1)'(128);
    return 66'(t >>> GUARD);
  endfunction

  logic adv;
  logic [30:0] eps_r;

  // stage 1: input register
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic signed [31:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r, s1_fa_r;
  logic [15:0]        s1_turn_r;

  // stage 2: products and prescaled lanes
  logic               s2_valid_r;
  logic signed [63:0] s2_p1_r, s2_p2_r, p1_nxt, p2_nxt;
  logic signed [XW-1:0] s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;
  logic signed [XW-1:0] pax_nxt, pay_nxt, pbx_nxt, pby_nxt;
  logic [15:0]        s2_turn_r;
  side_t              s2_side_r, s2_side_nxt;

  logic signed [32:0] dx, dy, srcx, srcy, adx, ady;
  logic signed [31:0] m1, m2;
  sat_t               sx, sy, ss;

  side_t c1_side_in;
  lane_t c1_a_in, c1_b_in;
  logic  c1_valid;
  lane_t c1_a, c1_b;
  side_t c1_side;

  logic        mid_valid_r;
  side_t       mid_side_r, mid_side_nxt;
  logic [31:0] mid_za_r;
  logic [31:0] za, zb;
  sat_t        mx, my, mm;

  lane_t c2_a_in, c2_b_in;
  logic  c2_valid;
  lane_t c2_a, c2_b;
  side_t c2_side;

  logic  out_valid_r;
  side_t out_side_r, out_side_nxt;
  sat_t  fx, fy;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= op_t'(in_opcode);
      s1_ax_r   <= in_ax;
      s1_ay_r   <= in_ay;
      s1_bx_r   <= in_bx;
      s1_by_r   <= in_by;
      s1_fa_r   <= in_factor;
      s1_turn_r <= in_turn;
    end
  end

  // stage 2 logic
  always_comb begin
    dx   = 33'(s1_ax_r) - 33'(s1_bx_r);
    dy   = 33'(s1_ay_r) - 33'(s1_by_r);
    adx  = dx[32] ? -dx : dx;
    ady  = dy[32] ? -dy : dy;
    srcx = (s1_op_r == OP_ROT_ABOUT) ? dx : 33'(s1_ax_r);
    srcy = (s1_op_r == OP_ROT_ABOUT) ? dy : 33'(s1_ay_r);
    pax_nxt = prescale(srcx);
    pay_nxt = prescale(srcy);
    pbx_nxt = prescale(33'(s1_bx_r));
    pby_nxt = prescale(33'(s1_by_r));
    m1 = (s1_op_r == OP_DOT) ? s1_bx_r : (s1_op_r == OP_CROSS) ? s1_by_r : s1_fa_r;
    m2 = (s1_op_r == OP_DOT) ? s1_by_r : (s1_op_r == OP_CROSS) ? s1_bx_r : s1_fa_r;
    p1_nxt = 64'(s1_ax_r) * 64'(m1);
    p2_nxt = 64'(s1_ay_r) * 64'(m2);

    s2_side_nxt    = '0;
    s2_side_nxt.op = s1_op_r;
    s2_side_nxt.bx = s1_bx_r;
    s2_side_nxt.by = s1_by_r;
    sx = '0;
    sy = '0;
    case (s1_op_r)
      OP_ADD: begin
        sx = sat32(66'(s1_ax_r) + 66'(s1_bx_r));
        sy = sat32(66'(s1_ay_r) + 66'(s1_by_r));
      end
      OP_SUB: begin
        sx = sat32(66'(dx));
        sy = sat32(66'(dy));
      end
      OP_NEG: begin
        sx = sat32(-66'(s1_ax_r));
        sy = sat32(-66'(s1_ay_r));
      end
      OP_UNIT: begin
        if (s1_ax_r == 32'sd0 && s1_ay_r == 32'sd0) s2_side_nxt.st = ST_ZERO;
      end
      OP_ANGLE: begin
        if ((s1_ax_r == 32'sd0 && s1_ay_r == 32'sd0) ||
            (s1_bx_r == 32'sd0 && s1_by_r == 32'sd0)) s2_side_nxt.st = ST_ZERO;
      end
      OP_EQ: begin
        s2_side_nxt.flag = (s1_ax_r == s1_bx_r) && (s1_ay_r == s1_by_r);
      end
      OP_WITHIN: begin
        s2_side_nxt.flag = ($unsigned(adx) < {2'b00, eps_r}) &&
                           ($unsigned(ady) < {2'b00, eps_r});
      end
      default: begin
      end
    endcase
    if (s1_op_r == OP_ADD || s1_op_r == OP_SUB || s1_op_r == OP_NEG) begin
      s2_side_nxt.rx = sx.val;
      s2_side_nxt.ry = sy.val;
      if (sx.ovf || sy.ovf) s2_side_nxt.st = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p1_r   <= p1_nxt;
      s2_p2_r   <= p2_nxt;
      s2_ax_r   <= pax_nxt;
      s2_ay_r   <= pay_nxt;
      s2_bx_r   <= pbx_nxt;
      s2_by_r   <= pby_nxt;
      s2_turn_r <= s1_turn_r;
      s2_side_r <= s2_side_nxt;
    end
  end

  // product rounding and cordic entry
  always_comb begin
    c1_side_in = s2_side_r;
    ss = '0;
    mm = '0;
    case (s2_side_r.op)
      OP_SCALE: begin
        ss = sat32((66'(s2_p1_r) + HALF) >>> FRAC_BITS);
        c1_side_in.rx = ss.val;
        mm = sat32((66'(s2_p2_r) + HALF) >>> FRAC_BITS);
        c1_side_in.ry = mm.val;
        if (ss.ovf || mm.ovf) c1_side_in.st = ST_SAT;
      end
      OP_DOT: begin
        ss = sat32((66'(s2_p1_r) + 66'(s2_p2_r) + HALF) >>> FRAC_BITS);
        c1_side_in.sc = ss.val;
        if (ss.ovf) c1_side_in.st = ST_SAT;
      end
      OP_CROSS: begin
        ss = sat32((66'(s2_p1_r) - 66'(s2_p2_r) + HALF) >>> FRAC_BITS);
        c1_side_in.sc = ss.val;
        if (ss.ovf) c1_side_in.st = ST_SAT;
      end
      default: begin
      end
    endcase
    if (s2_side_r.op == OP_ROT || s2_side_r.op == OP_ROT_ABOUT) begin
      c1_a_in = rot_prep(s2_ax_r, s2_ay_r, {s2_turn_r, 16'd0});
    end else begin
      c1_a_in = vec_prep(s2_ax_r, s2_ay_r);
    end
    c1_b_in = vec_prep(s2_bx_r, s2_by_r);
  end

  vc_chain #(.LEN(CORDIC_STAGES)) u_chain_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (s2_valid_r),
    .in_a     (c1_a_in),
    .in_b     (c1_b_in),
    .in_side  (c1_side_in),
    .out_valid(c1_valid),
    .out_a    (c1_a),
    .out_b    (c1_b),
    .out_side (c1_side)
  );

  // mid stage: results of the first cell row
  always_comb begin
    mid_side_nxt = c1_side;
    za = c1_a.z[31:0];
    zb = c1_b.z[31:0];
    mx = '0;
    my = '0;
    case (c1_side.op)
      OP_ROT: begin
        mx = sat32(rnd_g(c1_a.x));
        my = sat32(rnd_g(c1_a.y));
        mid_side_nxt.rx = mx.val;
        mid_side_nxt.ry = my.val;
        if (mx.ovf || my.ovf) mid_side_nxt.st = ST_SAT;
      end
      OP_ROT_ABOUT: begin
        mx = sat32(rnd_g(c1_a.x) + 66'(c1_side.bx));
        my = sat32(rnd_g(c1_a.y) + 66'(c1_side.by));
        mid_side_nxt.rx = mx.val;
        mid_side_nxt.ry = my.val;
        if (mx.ovf || my.ovf) mid_side_nxt.st = ST_SAT;
      end
      OP_MAG: begin
        mx = sat32(rnd_g(c1_a.x));
        mid_side_nxt.sc = mx.val;
        if (mx.ovf) mid_side_nxt.st = ST_SAT;
      end
      OP_ANGLE: begin
        if (c1_side.st != ST_ZERO) begin
          mid_side_nxt.ang = 16'((za - zb + 32'h00008000) >> 16);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (adv) begin
      mid_valid_r <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_side_r <= mid_side_nxt;
      mid_za_r   <= za;
    end
  end

  assign c2_a_in = rot_prep(UNIT_K, '0, mid_za_r);
  assign c2_b_in = '0;

  vc_chain #(.LEN(CORDIC_STAGES)) u_chain_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (mid_valid_r),
    .in_a     (c2_a_in),
    .in_b     (c2_b_in),
    .in_side  (mid_side_r),
    .out_valid(c2_valid),
    .out_a    (c2_a),
    .out_b    (c2_b),
    .out_side (c2_side)
  );

  // unit vector result and output register
  always_comb begin
    out_side_nxt = c2_side;
    fx = sat32(rnd_g(c2_a.x));
    fy = sat32(rnd_g(c2_a.y));
    if (c2_side.op == OP_UNIT && c2_side.st != ST_ZERO) begin
      out_side_nxt.rx = fx.val;
      out_side_nxt.ry = fy.val;
      if (fx.ovf || fy.ovf) out_side_nxt.st = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side_r <= out_side_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rx         = out_side_r.rx;
  assign out_ry         = out_side_r.ry;
  assign out_scalar_out = out_side_r.sc;
  assign out_angle_out  = out_side_r.ang;
  assign out_flag       = out_side_r.flag;
  assign out_status     = out_side_r.st;
endmodule
`default_nettype wire

### rtl/vc_checker.sv
`default_nettype none
`include "vector2d_cordic_unit_macros.svh"
module vc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_rx,
  input logic signed [31:0] out_ry,
  input logic signed [31:0] out_scalar_out,
  input logic [15:0]        out_angle_out,
  input logic               out_flag,
  input logic [1:0]         out_status
);
  import vc_pkg::*;

  `VC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `VC_ASSERT_IMP(a_zero_clean, clk, rst_n, out_valid && out_status == ST_ZERO, out_rx == 32'sd0 && out_ry == 32'sd0 && out_scalar_out == 32'sd0 && out_angle_out == 16'd0)
  `VC_ASSERT_IMP(a_flag_only, clk, rst_n, out_valid && out_flag, out_status == ST_OK && out_rx == 32'sd0 && out_ry == 32'sd0 && out_scalar_out == 32'sd0)
  `VC_ASSERT_IMP(a_angle_only, clk, rst_n, out_valid && out_angle_out != 16'd0, out_status == ST_OK && out_rx == 32'sd0 && out_scalar_out == 32'sd0 && !out_flag)
endmodule

bind vector2d_cordic_unit vc_checker u_vc_checker (.*);
`default_nettype wire
